@@ hdl/vm_instruction_execute_defines.svh @@
// Assertion macros shared by the execute unit RTL.
`ifndef VM_INSTRUCTION_EXECUTE_DEFINES_SVH
`define VM_INSTRUCTION_EXECUTE_DEFINES_SVH
`ifndef SYNTH
`define VMIE_ASSERT(lbl, cond) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond)) \
        else $error("vmie: invariant violated");
`define VMIE_ASSERT_IMP(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("vmie: same-cycle implication violated");
`define VMIE_ASSERT_NXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("vmie: next-cycle implication violated");
`else
`define VMIE_ASSERT(lbl, cond)
`define VMIE_ASSERT_IMP(lbl, ante, cons)
`define VMIE_ASSERT_NXT(lbl, ante, cons)
`endif
`endif

@@ hdl/vmie_pkg.sv @@
// Types, operation codes and helper functions of the execute unit.
`default_nettype none
package vmie_pkg;

    localparam logic [4:0] CMD_COPY  = 5'd0;
    localparam logic [4:0] CMD_EQ    = 5'd1;
    localparam logic [4:0] CMD_NE    = 5'd2;
    localparam logic [4:0] CMD_LT    = 5'd3;
    localparam logic [4:0] CMD_GE    = 5'd4;
    localparam logic [4:0] CMD_LE    = 5'd5;
    localparam logic [4:0] CMD_GT    = 5'd6;
    localparam logic [4:0] CMD_ADD   = 5'd7;
    localparam logic [4:0] CMD_SUB   = 5'd8;
    localparam logic [4:0] CMD_MUL   = 5'd9;
    localparam logic [4:0] CMD_DIV   = 5'd10;
    localparam logic [4:0] CMD_MOD   = 5'd11;
    localparam logic [4:0] CMD_AND   = 5'd12;
    localparam logic [4:0] CMD_SHR   = 5'd13;
    localparam logic [4:0] CMD_INC   = 5'd14;
    localparam logic [4:0] CMD_NEG   = 5'd15;
    localparam logic [4:0] CMD_GOTO  = 5'd16;
    localparam logic [4:0] CMD_JEQ   = 5'd17;
    localparam logic [4:0] CMD_JNE   = 5'd18;
    localparam logic [4:0] CMD_JLT   = 5'd19;
    localparam logic [4:0] CMD_JGE   = 5'd20;
    localparam logic [4:0] CMD_JLE   = 5'd21;
    localparam logic [4:0] CMD_JGT   = 5'd22;
    localparam logic [4:0] CMD_LOOP  = 5'd23;
    localparam logic [4:0] CMD_PRINT = 5'd24;
    localparam logic [4:0] CMD_NOP   = 5'd25;
    localparam logic [4:0] CMD_END   = 5'd26;
    localparam logic [4:0] CMD_LDI   = 5'd27;

    localparam logic [2:0] COND_EQ = 3'd0;
    localparam logic [2:0] COND_NE = 3'd1;
    localparam logic [2:0] COND_LT = 3'd2;
    localparam logic [2:0] COND_GE = 3'd3;
    localparam logic [2:0] COND_LE = 3'd4;

    // Remainder width: holds twice the largest modulus (program depth up to 131072).
    localparam int RW = 18;

    typedef struct packed {
        logic [4:0]         command;
        logic [7:0]         dest_index;
        logic [7:0]         src_a_index;
        logic [7:0]         src_b_index;
        logic [10:0]        jump_target;
        logic [10:0]        current_pc;
        logic signed [31:0] immediate_value;
    } vmie_in_t;

    typedef struct packed {
        logic [10:0]        next_pc;
        logic               print_valid;
        logic signed [31:0] print_value;
        logic               halted;
        logic               divide_error;
    } vmie_out_t;

    // Classified item as queued between front and back.
    typedef struct packed {
        logic [4:0]  cmd;
        logic [7:0]  dest;
        logic [7:0]  rd_a;
        logic [7:0]  rd_b;
        logic [7:0]  src_a;
        logic [10:0] target;
        logic [10:0] pc;
        logic [10:0] fall_pc;
        logic [31:0] imm;
    } vmie_entry_t;

    // Six restoring remainder steps: fold six more bits into r modulo m.
    function automatic logic [RW-1:0] mod_bits(input logic [RW-1:0] r,
                                               input logic [5:0] bits,
                                               input logic [RW-1:0] m);
        logic [RW-1:0] acc;
        acc = r;
        for (int k = 5; k >= 0; k--) begin
            acc = {acc[RW-2:0], bits[k]};
            if (acc >= m) begin
                acc = acc - m;
            end
        end
        return acc;
    endfunction

    function automatic logic cond_true(input logic [2:0] sel,
                                       input logic [31:0] a,
                                       input logic [31:0] b);
        logic res;
        case (sel)
            COND_EQ: res = (a == b);
            COND_NE: res = (a != b);
            COND_LT: res = ($signed(a) < $signed(b));
            COND_GE: res = !($signed(a) < $signed(b));
            COND_LE: res = !($signed(b) < $signed(a));
            default: res = ($signed(b) < $signed(a));
        endcase
        return res;
    endfunction

endpackage
`default_nettype wire

@@ hdl/vmie_front.sv @@
// Front end: accepts an item, reduces indices and addresses, classifies it.
`default_nettype none
module vmie_front #(
    parameter int VAR_COUNT  = 256,
    parameter int PROG_DEPTH = 2048
) (
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  start,
    input  wire vmie_pkg::vmie_in_t    item,
    output logic                       busy,
    input  wire logic                  q_full,
    output logic                       q_push,
    output vmie_pkg::vmie_entry_t      q_entry
);
    import vmie_pkg::*;

    typedef enum logic {F_IDLE, F_FIN} fstate_t;

    localparam logic [RW-1:0] VMOD = RW'(VAR_COUNT);
    localparam logic [RW-1:0] PMOD = RW'(PROG_DEPTH);

    fstate_t       state_reg, state_next;
    vmie_in_t      item_reg, item_next;
    logic [RW-1:0] rd_reg, rd_next, ra_reg, ra_next, rb_reg, rb_next;
    logic [RW-1:0] rt_reg, rt_next, rp_reg, rp_next;
    logic [11:0]   pc_inc;
    logic [11:0]   pc_inc_reg, pc_inc_next;
    logic [RW-1:0] d_fin, a_fin, b_fin, t_fin, p_fin;
    logic [4:0]    cmd_cls;

    assign busy   = (state_reg != F_IDLE) || q_full;
    assign pc_inc = {1'b0, item.current_pc} + 12'd1;

    // Bits above the low six of each value are folded on acceptance, the rest next cycle.
    always_comb
    begin
        state_next  = state_reg;
        item_next   = item_reg;
        rd_next     = rd_reg;
        ra_next     = ra_reg;
        rb_next     = rb_reg;
        rt_next     = rt_reg;
        rp_next     = rp_reg;
        pc_inc_next = pc_inc_reg;
        case (state_reg)
            F_IDLE:
            begin
                if (start && !busy)
                begin
                    item_next   = item;
                    rd_next     = mod_bits('0, {4'b0, item.dest_index[7:6]}, VMOD);
                    ra_next     = mod_bits('0, {4'b0, item.src_a_index[7:6]}, VMOD);
                    rb_next     = mod_bits('0, {4'b0, item.src_b_index[7:6]}, VMOD);
                    rt_next     = mod_bits('0, {1'b0, item.jump_target[10:6]}, PMOD);
                    rp_next     = mod_bits('0, pc_inc[11:6], PMOD);
                    pc_inc_next = pc_inc;
                    state_next  = F_FIN;
                end
            end
            F_FIN:
            begin
                if (!q_full)
                begin
                    state_next = F_IDLE;
                end
            end
            default: state_next = F_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= F_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_ff @(posedge clk)
    begin
        item_reg   <= item_next;
        rd_reg     <= rd_next;
        ra_reg     <= ra_next;
        rb_reg     <= rb_next;
        rt_reg     <= rt_next;
        rp_reg     <= rp_next;
        pc_inc_reg <= pc_inc_next;
    end

    assign d_fin = mod_bits(rd_reg, item_reg.dest_index[5:0], VMOD);
    assign a_fin = mod_bits(ra_reg, item_reg.src_a_index[5:0], VMOD);
    assign b_fin = mod_bits(rb_reg, item_reg.src_b_index[5:0], VMOD);
    assign t_fin = mod_bits(rt_reg, item_reg.jump_target[5:0], PMOD);
    assign p_fin = mod_bits(rp_reg, pc_inc_reg[5:0], PMOD);

    // Unused codes behave as no-op.
    assign cmd_cls = (item_reg.command > CMD_LDI) ? CMD_NOP : item_reg.command;

    always_comb
    begin
        q_entry.cmd     = cmd_cls;
        q_entry.dest    = d_fin[7:0];
        q_entry.src_a   = a_fin[7:0];
        q_entry.rd_b    = b_fin[7:0];
        q_entry.rd_a    = ((cmd_cls == CMD_INC) || (cmd_cls == CMD_PRINT)) ?
                          d_fin[7:0] : a_fin[7:0];
        q_entry.target  = t_fin[10:0];
        q_entry.fall_pc = p_fin[10:0];
        q_entry.pc      = item_reg.current_pc;
        q_entry.imm     = item_reg.immediate_value;
    end

    assign q_push = (state_reg == F_FIN) && !q_full;

endmodule
`default_nettype wire

@@ hdl/vmie_queue.sv @@
// Two-entry queue between the front end and the execute back end.
`default_nettype none
module vmie_queue (
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  push,
    input  wire vmie_pkg::vmie_entry_t wr_entry,
    input  wire logic                  pop,
    output vmie_pkg::vmie_entry_t      rd_entry,
    output logic                       full,
    output logic                       empty
);
    import vmie_pkg::*;

    vmie_entry_t slot_reg [2];
    logic        wp_reg, rp_reg;
    logic [1:0]  cnt_reg;

    assign full     = (cnt_reg == 2'd2);
    assign empty    = (cnt_reg == 2'd0);
    assign rd_entry = slot_reg[rp_reg];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wp_reg  <= 1'b0;
            rp_reg  <= 1'b0;
            cnt_reg <= 2'd0;
        end
        else
        begin
            if (push && !full)
            begin
                wp_reg <= !wp_reg;
            end
            if (pop && !empty)
            begin
                rp_reg <= !rp_reg;
            end
            cnt_reg <= cnt_reg + 2'((push && !full) ? 1 : 0) - 2'((pop && !empty) ? 1 : 0);
        end
    end

    always_ff @(posedge clk)
    begin
        if (push && !full)
        begin
            slot_reg[wp_reg] <= wr_entry;
        end
    end

endmodule
`default_nettype wire

@@ hdl/vmie_back.sv @@
// Back end: variable store, ALU, iterative divider and result register.
`default_nettype none
module vmie_back #(
    parameter int VAR_COUNT = 256
) (
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  q_empty,
    input  wire vmie_pkg::vmie_entry_t q_entry,
    output logic                       q_pop,
    output logic                       done,
    output vmie_pkg::vmie_out_t        result
);
    import vmie_pkg::*;

    localparam int AW = (VAR_COUNT > 1) ? $clog2(VAR_COUNT) : 1;

    typedef enum logic [1:0] {B_IDLE, B_EXEC, B_DIV, B_FIN} bstate_t;

    logic [31:0]  mem [VAR_COUNT];
    logic [31:0]  rd_a_reg, rd_b_reg;
    logic         we;
    logic [7:0]   wa;
    logic [31:0]  wd;

    bstate_t      state_reg, state_next;
    vmie_entry_t  ent_reg, ent_next;
    logic         done_reg, done_next;
    vmie_out_t    result_reg, result_next;
    logic [31:0]  dv_rem_reg, dv_rem_next, dv_quo_reg, dv_quo_next;
    logic [31:0]  dv_den_reg, dv_den_next;
    logic [4:0]   dv_cnt_reg, dv_cnt_next;
    logic         a_neg_reg, a_neg_next, b_neg_reg, b_neg_next;

    logic [31:0]  a, b, a_inc, b_eff, prod;
    logic [4:0]   sh_amt;
    logic [32:0]  dv_trial;
    logic         dv_ge;
    logic [10:0]  nxt;

    function automatic logic [AW-1:0] to_addr(input logic [7:0] idx);
        logic [AW+7:0] ext;
        ext = {{AW{1'b0}}, idx};
        return ext[AW-1:0];
    endfunction

    // Registered read each cycle; only the read at pop is used, writes come later.
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[to_addr(wa)] <= wd;
        end
        rd_a_reg <= mem[to_addr(q_entry.rd_a)];
        rd_b_reg <= mem[to_addr(q_entry.rd_b)];
    end

    assign q_pop  = (state_reg == B_IDLE) && !q_empty;
    assign a      = rd_a_reg;
    assign b      = rd_b_reg;
    assign a_inc  = a + 32'd1;
    // Loop re-reads the limit after the counter update.
    assign b_eff  = (ent_reg.src_a == ent_reg.rd_b) ? a_inc : b;
    assign prod   = a * b;
    assign sh_amt = b[31] ? 5'd0 : ((b > 32'd31) ? 5'd31 : b[4:0]);

    assign dv_trial = {dv_rem_reg, dv_quo_reg[31]};
    assign dv_ge    = dv_trial >= {1'b0, dv_den_reg};

    always_comb
    begin
        state_next  = state_reg;
        ent_next    = ent_reg;
        done_next   = 1'b0;
        result_next = result_reg;
        dv_rem_next = dv_rem_reg;
        dv_quo_next = dv_quo_reg;
        dv_den_next = dv_den_reg;
        dv_cnt_next = dv_cnt_reg;
        a_neg_next  = a_neg_reg;
        b_neg_next  = b_neg_reg;
        we          = 1'b0;
        wa          = ent_reg.dest;
        wd          = '0;
        nxt         = ent_reg.fall_pc;

        case (state_reg)
            B_IDLE:
            begin
                if (!q_empty)
                begin
                    ent_next   = q_entry;
                    state_next = B_EXEC;
                end
            end
            B_EXEC:
            begin
                result_next = '{next_pc: ent_reg.fall_pc, print_valid: 1'b0,
                                print_value: '0, halted: 1'b0, divide_error: 1'b0};
                done_next   = 1'b1;
                state_next  = B_IDLE;
                case (ent_reg.cmd)
                    CMD_COPY: begin we = 1'b1; wd = a; end
                    CMD_EQ, CMD_NE, CMD_LT, CMD_GE, CMD_LE, CMD_GT:
                    begin
                        we = 1'b1;
                        wd = {31'b0, cond_true(3'(ent_reg.cmd - CMD_EQ), a, b)};
                    end
                    CMD_ADD: begin we = 1'b1; wd = a + b; end
                    CMD_SUB: begin we = 1'b1; wd = a - b; end
                    CMD_MUL: begin we = 1'b1; wd = prod; end
                    CMD_DIV, CMD_MOD:
                    begin
                        if (b == 32'd0)
                        begin
                            we = 1'b1;
                            result_next.divide_error = 1'b1;
                        end
                        else
                        begin
                            // Hand over magnitudes to the divider.
                            done_next   = 1'b0;
                            state_next  = B_DIV;
                            dv_rem_next = '0;
                            dv_quo_next = a[31] ? (32'd0 - a) : a;
                            dv_den_next = b[31] ? (32'd0 - b) : b;
                            dv_cnt_next = '0;
                            a_neg_next  = a[31];
                            b_neg_next  = b[31];
                        end
                    end
                    CMD_AND: begin we = 1'b1; wd = a & b; end
                    CMD_SHR: begin we = 1'b1; wd = 32'($signed(a) >>> sh_amt); end
                    CMD_INC: begin we = 1'b1; wd = a_inc; end
                    CMD_NEG: begin we = 1'b1; wd = 32'd0 - a; end
                    CMD_GOTO: nxt = ent_reg.target;
                    CMD_JEQ, CMD_JNE, CMD_JLT, CMD_JGE, CMD_JLE, CMD_JGT:
                    begin
                        if (cond_true(3'(ent_reg.cmd - CMD_JEQ), a, b))
                        begin
                            nxt = ent_reg.target;
                        end
                    end
                    CMD_LOOP:
                    begin
                        we = 1'b1;
                        wa = ent_reg.src_a;
                        wd = a_inc;
                        if ($signed(a_inc) < $signed(b_eff))
                        begin
                            nxt = ent_reg.target;
                        end
                    end
                    CMD_PRINT:
                    begin
                        result_next.print_valid = 1'b1;
                        result_next.print_value = a;
                    end
                    CMD_END:
                    begin
                        result_next.halted = 1'b1;
                        nxt = ent_reg.pc;
                    end
                    CMD_LDI: begin we = 1'b1; wd = ent_reg.imm; end
                    default: ;
                endcase
                result_next.next_pc = nxt;
            end
            B_DIV:
            begin
                // One restoring step per cycle, 32 in all.
                dv_rem_next = dv_ge ? 32'(dv_trial - {1'b0, dv_den_reg}) : dv_trial[31:0];
                dv_quo_next = {dv_quo_reg[30:0], dv_ge};
                dv_cnt_next = dv_cnt_reg + 5'd1;
                if (dv_cnt_reg == 5'd31)
                begin
                    state_next = B_FIN;
                end
            end
            B_FIN:
            begin
                we = 1'b1;
                if (ent_reg.cmd == CMD_DIV)
                begin
                    wd = (a_neg_reg != b_neg_reg) ? (32'd0 - dv_quo_reg) : dv_quo_reg;
                end
                else
                begin
                    wd = a_neg_reg ? (32'd0 - dv_rem_reg) : dv_rem_reg;
                end
                result_next = '{next_pc: ent_reg.fall_pc, print_valid: 1'b0,
                                print_value: '0, halted: 1'b0, divide_error: 1'b0};
                done_next   = 1'b1;
                state_next  = B_IDLE;
            end
            default: state_next = B_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= B_IDLE;
            done_reg   <= 1'b0;
            result_reg <= '0;
            ent_reg    <= '0;
            dv_rem_reg <= '0;
            dv_quo_reg <= '0;
            dv_den_reg <= '0;
            dv_cnt_reg <= '0;
            a_neg_reg  <= 1'b0;
            b_neg_reg  <= 1'b0;
        end
        else
        begin
            state_reg  <= state_next;
            done_reg   <= done_next;
            result_reg <= result_next;
            ent_reg    <= ent_next;
            dv_rem_reg <= dv_rem_next;
            dv_quo_reg <= dv_quo_next;
            dv_den_reg <= dv_den_next;
            dv_cnt_reg <= dv_cnt_next;
            a_neg_reg  <= a_neg_next;
            b_neg_reg  <= b_neg_next;
        end
    end

    assign done   = done_reg;
    assign result = result_reg;

endmodule
`default_nettype wire

@@ hdl/vm_instruction_execute.sv @@
// Execute unit of a small register-memory virtual machine (top level).
//
// Usage: drive a decoded instruction on item and raise start; the item is
// taken at the rising edge where start is high and busy is low. Each item
// yields exactly one result, shown on result for one cycle with done high.
// The receiver cannot hold results off: sample result whenever done is set.
//
// Front end reduces indices and addresses on acceptance and in F_FIN, then
// hands the item over a two-entry queue to the back end. The back end reads
// both operands from the variable store (registered read) at pop and executes
// in the next cycle, from which done and result are registered.
// A new item is taken only once the last has been pushed and the queue is not
// full. Divide and modulo with a non-zero divisor run the 32-step restoring
// divider in B_DIV; meanwhile the queue fills and busy holds the input off.
//
// Reset clears control state only; the variable store holds no reset value
// and an entry must be written before it is read.
`default_nettype none
`include "vm_instruction_execute_defines.svh"
module vm_instruction_execute #(
    parameter int VAR_COUNT  = 256,
    parameter int PROG_DEPTH = 2048
) (
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic                start,
    input  wire vmie_pkg::vmie_in_t  item,
    output logic                     busy,
    output logic                     done,
    output vmie_pkg::vmie_out_t      result
);
    import vmie_pkg::*;

    logic        q_full, q_empty, q_push, q_pop;
    vmie_entry_t q_wr, q_rd;

    // Accept and classify.
    vmie_front #(.VAR_COUNT(VAR_COUNT), .PROG_DEPTH(PROG_DEPTH)) u_front (
        .clk     (clk),
        .rst_n   (rst_n),
        .start   (start),
        .item    (item),
        .busy    (busy),
        .q_full  (q_full),
        .q_push  (q_push),
        .q_entry (q_wr)
    );

    // Decouple front and back.
    vmie_queue u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (q_push),
        .wr_entry (q_wr),
        .pop      (q_pop),
        .rd_entry (q_rd),
        .full     (q_full),
        .empty    (q_empty)
    );

    // Execute and report.
    vmie_back #(.VAR_COUNT(VAR_COUNT)) u_back (
        .clk     (clk),
        .rst_n   (rst_n),
        .q_empty (q_empty),
        .q_entry (q_rd),
        .q_pop   (q_pop),
        .done    (done),
        .result  (result)
    );

    // Each item passes through B_IDLE and B_EXEC, so done is never high back to back.
    `VMIE_ASSERT_NXT(a_done_gap, done, !done)
    // Accepting an item always occupies the front end for the next cycle.
    `VMIE_ASSERT_NXT(a_accept_busy, start && !busy, busy)
    // A result carries at most one kind of event.
    `VMIE_ASSERT_IMP(a_one_event, done,
        !(result.print_valid && result.halted) &&
        !(result.print_valid && result.divide_error) &&
        !(result.halted && result.divide_error))
    // No print value without a print.
    `VMIE_ASSERT(a_print_zero, !done || result.print_valid || (result.print_value == 32'sd0))

endmodule
`default_nettype wire

@@ bench/vm_instruction_execute_checker.sv @@
// Checker for the execute unit: predicts each result and compares it on arrival.
`timescale 1ns / 1ps
module vm_instruction_execute_checker
    import vmie_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      start,
    input  logic      busy,
    input  vmie_in_t  item,
    input  logic      done,
    input  vmie_out_t result,
    output int        errors,
    output int        pending
);
    logic [31:0] shadow_vars [256];
    vmie_out_t   awaited_results [$];

    function automatic logic holds(input logic [2:0] sel, input logic [31:0] a,
                                   input logic [31:0] b);
        case (sel)
            3'd0:    return a == b;
            3'd1:    return a != b;
            3'd2:    return $signed(a) < $signed(b);
            3'd3:    return $signed(a) >= $signed(b);
            3'd4:    return $signed(a) <= $signed(b);
            default: return $signed(a) > $signed(b);
        endcase
    endfunction

    // Execute one instruction on the shadow store and return what it yields.
    function automatic vmie_out_t execute_instr(input vmie_in_t ins);
        vmie_out_t   r;
        logic [31:0] a, b;
        logic [4:0]  amt;
        a = shadow_vars[ins.src_a_index];
        b = shadow_vars[ins.src_b_index];
        r = '0;
        r.next_pc = ins.current_pc + 11'd1;
        case (ins.command)
            CMD_COPY: shadow_vars[ins.dest_index] = a;
            CMD_EQ, CMD_NE, CMD_LT, CMD_GE, CMD_LE, CMD_GT:
                shadow_vars[ins.dest_index] =
                    {31'd0, holds(3'(ins.command - CMD_EQ), a, b)};
            CMD_ADD: shadow_vars[ins.dest_index] = a + b;
            CMD_SUB: shadow_vars[ins.dest_index] = a - b;
            CMD_MUL: shadow_vars[ins.dest_index] = a * b;
            CMD_DIV, CMD_MOD:
            begin
                if (b == 0)
                begin
                    shadow_vars[ins.dest_index] = '0;
                    r.divide_error = 1'b1;
                end
                else if (a == 32'h8000_0000 && b == 32'hFFFF_FFFF)
                    // overflow: quotient wraps to itself, remainder is zero
                    shadow_vars[ins.dest_index] = (ins.command == CMD_DIV) ? a : '0;
                else if (ins.command == CMD_DIV)
                    shadow_vars[ins.dest_index] = $signed(a) / $signed(b);
                else
                    shadow_vars[ins.dest_index] = $signed(a) % $signed(b);
            end
            CMD_AND: shadow_vars[ins.dest_index] = a & b;
            CMD_SHR:
            begin
                amt = b[31] ? 5'd0 : (b > 31) ? 5'd31 : b[4:0];
                shadow_vars[ins.dest_index] = $signed(a) >>> amt;
            end
            CMD_INC: shadow_vars[ins.dest_index] = shadow_vars[ins.dest_index] + 1;
            CMD_NEG: shadow_vars[ins.dest_index] = -a;
            CMD_GOTO: r.next_pc = ins.jump_target;
            CMD_JEQ, CMD_JNE, CMD_JLT, CMD_JGE, CMD_JLE, CMD_JGT:
                if (holds(3'(ins.command - CMD_JEQ), a, b))
                    r.next_pc = ins.jump_target;
            CMD_LOOP:
            begin
                shadow_vars[ins.src_a_index] = a + 1;
                if ($signed(a + 1) < $signed(shadow_vars[ins.src_b_index]))
                    r.next_pc = ins.jump_target;
            end
            CMD_PRINT:
            begin
                r.print_valid = 1'b1;
                r.print_value = shadow_vars[ins.dest_index];
            end
            CMD_END:
            begin
                r.halted  = 1'b1;
                r.next_pc = ins.current_pc;
            end
            CMD_LDI: shadow_vars[ins.dest_index] = ins.immediate_value;
            default: ;
        endcase
        return r;
    endfunction

    task automatic flag(input string field, input logic [31:0] want, input logic [31:0] got);
        $display("%0t: %s mismatch, expected %0h, actual %0h", $time, field, want, got);
        errors++;
    endtask

    assign pending = awaited_results.size();

    initial errors = 0;

    // Compare first, then record the newly accepted item: a result can never
    // belong to the item taken at the same edge.
    always @(posedge clk)
    begin
        vmie_out_t want;
        if (rst_n)
        begin
            if (done)
            begin
                if (awaited_results.size() == 0)
                begin
                    $display("%0t: unexpected result, actual %0h", $time, result);
                    errors++;
                end
                else
                begin
                    want = awaited_results.pop_front();
                    if (result.next_pc !== want.next_pc)
                        flag("next_pc", want.next_pc, result.next_pc);
                    if (result.print_valid !== want.print_valid)
                        flag("print_valid", want.print_valid, result.print_valid);
                    if (result.print_value !== want.print_value)
                        flag("print_value", want.print_value, result.print_value);
                    if (result.halted !== want.halted)
                        flag("halted", want.halted, result.halted);
                    if (result.divide_error !== want.divide_error)
                        flag("divide_error", want.divide_error, result.divide_error);
                end
            end
            if (start && !busy)
                awaited_results.push_back(execute_instr(item));
        end
    end
endmodule

@@ bench/vm_instruction_execute_tb.sv @@
// Testbench top for the execute unit: stimulus, watchdog and verdict.
`timescale 1ns / 1ps
module vm_instruction_execute_tb;
    import vmie_pkg::*;

    localparam int WATCHDOG_LIMIT = 3000;
    localparam int RANDOM_ITEMS   = 1200;

    logic      clk;
    logic      rst_n;
    logic      start;
    vmie_in_t  item;
    logic      busy;
    logic      done;
    vmie_out_t result;
    int        errors;
    int        pending;
    int        quiet_cycles;

    // Variables written so far: only these may be read by an instruction.
    bit        var_written [256];
    logic [7:0] written_list [$];

    vm_instruction_execute uut (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (start),
        .item   (item),
        .busy   (busy),
        .done   (done),
        .result (result)
    );

    vm_instruction_execute_checker checker_i (
        .clk     (clk),
        .rst_n   (rst_n),
        .start   (start),
        .busy    (busy),
        .item    (item),
        .done    (done),
        .result  (result),
        .errors  (errors),
        .pending (pending)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // Watchdog: end the run if nothing moves on either side for too long.
    always @(posedge clk)
    begin
        if ((start && !busy) || done)
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= WATCHDOG_LIMIT)
        begin
            $display("DONE: errors detected");
            $finish;
        end
    end

    function automatic logic [7:0] known_var();
        return written_list[$urandom_range(0, written_list.size() - 1)];
    endfunction

    // Values biased towards the awkward corners: zero, ones, signs, shifts.
    function automatic logic [31:0] pick_value();
        case ($urandom_range(0, 9))
            0:       return 32'd0;
            1:       return 32'hFFFF_FFFF;
            2:       return 32'h8000_0000;
            3:       return 32'h7FFF_FFFF;
            4, 5:    return $urandom_range(0, 40);
            6:       return -$urandom_range(1, 40);
            default: return $urandom;
        endcase
    endfunction

    // Hold the item with start high until it is taken, then note its writes.
    task automatic issue(input vmie_in_t ins);
        @(negedge clk);
        start <= 1'b1;
        item  <= ins;
        do @(posedge clk); while (busy);
        if (ins.command <= CMD_MUL || ins.command inside {CMD_DIV, CMD_MOD, CMD_AND,
                                                          CMD_SHR, CMD_NEG, CMD_LDI})
        begin
            if (!var_written[ins.dest_index])
                written_list.push_back(ins.dest_index);
            var_written[ins.dest_index] = 1'b1;
        end
    endtask

    // Drop start for a while: mostly short gaps, now and then a long one.
    task automatic idle_gap();
        int gap;
        gap = ($urandom_range(0, 19) == 0) ? $urandom_range(10, 60) : $urandom_range(0, 2);
        if ($urandom_range(0, 3) == 0)
            gap = 0;
        if (gap > 0)
        begin
            @(negedge clk);
            start <= 1'b0;
            repeat (gap - 1) @(negedge clk);
        end
    endtask

    function automatic vmie_in_t build(input logic [4:0] cmd, input logic [7:0] d,
                                       input logic [7:0] a, input logic [7:0] b);
        vmie_in_t ins;
        ins.command         = cmd;
        ins.dest_index      = d;
        ins.src_a_index     = a;
        ins.src_b_index     = b;
        ins.jump_target     = 11'($urandom_range(0, 2047));
        ins.current_pc      = 11'($urandom_range(0, 2047));
        ins.immediate_value = pick_value();
        return ins;
    endfunction

    initial
    begin
        vmie_in_t   ins;
        logic [7:0] d;
        logic [31:0] seeds [9] = '{32'd0, 32'd1, 32'hFFFF_FFFF, 32'h7FFF_FFFF,
                                   32'h8000_0000, 32'd31, 32'd40, 32'd7,
                                   32'hFFFF_FFF9};
        logic [7:0]  slots [9] = '{8'd0, 8'd1, 8'd2, 8'd3, 8'd4, 8'd5, 8'd6,
                                   8'd255, 8'd128};
        quiet_cycles = 0;
        rst_n = 1'b0;
        start = 1'b0;
        item  = '0;
        repeat (2) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // Directed: seed the corner values, exercise divide, shift and loop corners, then every code 0 to 31 once.
        for (int i = 0; i < 9; i++)
        begin
            ins = build(CMD_LDI, slots[i], 8'd0, 8'd0);
            ins.immediate_value = seeds[i];
            issue(ins);
        end
        issue(build(CMD_DIV, 8'd10, 8'd4, 8'd2));    // most negative over minus one
        issue(build(CMD_MOD, 8'd11, 8'd4, 8'd2));
        issue(build(CMD_DIV, 8'd12, 8'd3, 8'd0));    // zero divisor
        issue(build(CMD_MOD, 8'd13, 8'd128, 8'd0));
        issue(build(CMD_MOD, 8'd14, 8'd128, 8'd5));  // remainder follows the dividend
        issue(build(CMD_SHR, 8'd15, 8'd4, 8'd6));    // amount beyond 31
        issue(build(CMD_SHR, 8'd16, 8'd3, 8'd2));    // negative amount
        issue(build(CMD_LOOP, 8'd0, 8'd255, 8'd6));
        for (int c = 0; c < 32; c++)
            issue(build(5'(c), 8'd20, known_var(), known_var()));

        // Hold off until every result is home.
        @(negedge clk);
        start <= 1'b0;
        wait (pending == 0);

        // Random part: mostly well-formed instructions over written variables.
        for (int n = 0; n < RANDOM_ITEMS; n++)
        begin
            case ($urandom_range(0, 9))
                0, 1, 2: ins = build(CMD_LDI, 8'($urandom_range(0, 255)),
                                     known_var(), known_var());
                3:       ins = build(5'($urandom_range(CMD_JEQ, CMD_LOOP)),
                                     known_var(), known_var(), known_var());
                4:       ins = build(5'($urandom_range(28, 31)),
                                     known_var(), known_var(), known_var());
                default: ins = build(5'($urandom_range(0, CMD_LDI)),
                                     8'($urandom_range(0, 255)), known_var(), known_var());
            endcase
            // Increment and print read their destination.
            if (ins.command inside {CMD_INC, CMD_PRINT} && !var_written[ins.dest_index])
                ins.dest_index = known_var();
            issue(ins);
            idle_gap();
        end

        @(negedge clk);
        start <= 1'b0;
        wait (pending == 0);
        repeat (50) @(posedge clk);
        if (errors == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end
endmodule

@@ filelist.f @@
+incdir+hdl
hdl/vmie_pkg.sv
hdl/vmie_front.sv
hdl/vmie_queue.sv
hdl/vmie_back.sv
hdl/vm_instruction_execute.sv
bench/vm_instruction_execute_checker.sv
bench/vm_instruction_execute_tb.sv
